@@ hw/rtl/gic_pkg.sv @@
// shared constants of the grid island counter
// no dependencies
`timescale 1ns / 1ps

package gic_pkg;

  // configuration port
  localparam int unsigned CfgW = 7;
  localparam logic CfgIdxRows = 1'b0;
  localparam logic CfgIdxCols = 1'b1;
  localparam logic [CfgW-1:0] CfgDimReset = 7'd64;

  // stream payloads
  localparam int unsigned InDataW  = 8;
  localparam int unsigned CountW   = 12;
  localparam int unsigned OutDataW = 16;
  localparam logic [CountW-1:0] CountMax = 12'hFFF;

endpackage

@@ hw/rtl/grid_island_counter_top.sv @@
// grid island counter: loads a binary grid, counts its 4-connected land regions
// depends on gic_pkg, gic_dims, gic_ram
// load: cells load at one transfer per cycle; after the last cell the block pads
//   missing cells with water, scans every cell, floods each region through the fill
//   stack, reading each in-grid neighbor of every popped cell, and registers the result
// throughput: one grid at a time, input not ready from the last cell until the count is
//   registered, which waits while the previous count is still not taken
// reset clears the sequencer, counters and result valid; dimensions reset to 64;
//   cell and stack memories come up undefined and are always written before read
`timescale 1ns / 1ps

module grid_island_counter_top
  import gic_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // cell stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] cell_land, rest zero
  input  logic                s_axis_tlast,   // cell_last
  // count stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [11:0] island_count, rest zero
  // register writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned MaxCells = MAX_ROWS * MAX_COLS;
  localparam int unsigned ColW  = $clog2(MAX_COLS + 1);
  localparam int unsigned PosW  = $clog2(MaxCells + 1);
  localparam int unsigned AddrW = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int unsigned StkW  = AddrW + ColW;   // stack entry: {linear index, column}

  typedef enum logic [3:0] {
    ST_LOAD,      // taking cells
    ST_FILL,      // early last: pad missing cells with water
    ST_SCAN_RD,   // read the cell under the raster scan
    ST_SCAN_CHK,  // land starts a new region
    ST_POP,       // pop the fill stack
    ST_NB_RD,     // read one neighbor of the popped cell
    ST_NB_CHK,    // land neighbor: clear and push
    ST_DONE       // hand the count to the output register
  } state_e;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  // dimensions
  logic [ColW-1:0] cols;
  logic [PosW-1:0] total;

  gic_dims #(
    .MaxRows (MAX_ROWS),
    .MaxCols (MAX_COLS)
  ) u_dims (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cols_o     (cols),
    .total_o    (total)
  );

  // sequencer state
  state_e            state_q;
  dir_e              dir_q;
  logic [PosW-1:0]   load_pos_q;
  logic [PosW-1:0]   scan_pos_q;
  logic [ColW-1:0]   scan_col_q;
  logic [PosW-1:0]   top_q;
  logic [CountW-1:0] count_q;
  logic [PosW-1:0]   nb_idx_q;
  logic [ColW-1:0]   nb_col_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_count_q;

  // memory ports
  logic             cell_we, cell_wdata, cell_re, cell_rdata;
  logic [AddrW-1:0] cell_waddr, cell_raddr;
  logic             stk_we, stk_re;
  logic [AddrW-1:0] stk_waddr, stk_raddr;
  logic [StkW-1:0]  stk_wdata, stk_rdata;

  gic_ram #(
    .Width (1),
    .Depth (MaxCells)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  gic_ram #(
    .Width (StkW),
    .Depth (MaxCells)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  logic in_fire, out_fire;
  logic load_in_grid, scan_at_end, top_empty;
  logic [PosW-1:0] top_dec;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign out_fire     = m_axis_tvalid && m_axis_tready;
  assign load_in_grid = (load_pos_q < total);
  assign scan_at_end  = (scan_pos_q == (total - PosW'(1)));
  assign top_empty    = (top_q == '0);
  assign top_dec      = top_q - PosW'(1);

  // neighbor of the popped cell; the stack read data holds until the next pop
  logic [PosW-1:0] cur_idx;
  logic [ColW-1:0] cur_col;
  logic [PosW:0]   down_sum;
  logic            nb_ok;
  logic [PosW-1:0] nb_idx;
  logic [ColW-1:0] nb_col;

  assign cur_idx  = PosW'(stk_rdata[StkW-1:ColW]);
  assign cur_col  = stk_rdata[ColW-1:0];
  assign down_sum = {1'b0, cur_idx} + (PosW + 1)'(cols);

  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_idx;
    nb_col = cur_col;
    case (dir_q)
      DIR_UP: begin
        nb_ok  = (cur_idx >= PosW'(cols));
        nb_idx = cur_idx - PosW'(cols);
      end
      DIR_DOWN: begin
        nb_ok  = (down_sum < {1'b0, total});
        nb_idx = down_sum[PosW-1:0];
      end
      DIR_LEFT: begin
        nb_ok  = (cur_col != '0);
        nb_idx = cur_idx - PosW'(1);
        nb_col = cur_col - ColW'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = ((cur_col + ColW'(1)) < cols);
        nb_idx = cur_idx + PosW'(1);
        nb_col = cur_col + ColW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = load_pos_q[AddrW-1:0];
    cell_wdata = 1'b0;
    cell_re    = 1'b0;
    cell_raddr = scan_pos_q[AddrW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = top_q[AddrW-1:0];
    stk_wdata  = {nb_idx_q[AddrW-1:0], nb_col_q};
    stk_re     = 1'b0;
    stk_raddr  = top_dec[AddrW-1:0];
    case (state_q)
      ST_LOAD: begin
        cell_we    = in_fire && load_in_grid;
        cell_wdata = s_axis_tdata[0];
      end
      ST_FILL: begin
        cell_we = load_in_grid;
      end
      ST_SCAN_RD: begin
        cell_re = 1'b1;
      end
      ST_SCAN_CHK: begin
        // region seed: clear it and make it the only stack entry
        if (cell_rdata) begin
          cell_we    = 1'b1;
          cell_waddr = scan_pos_q[AddrW-1:0];
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = {scan_pos_q[AddrW-1:0], scan_col_q};
        end
      end
      ST_POP: begin
        stk_re = !top_empty;
      end
      ST_NB_RD: begin
        cell_re    = nb_ok;
        cell_raddr = nb_idx[AddrW-1:0];
      end
      ST_NB_CHK: begin
        if (cell_rdata) begin
          cell_we    = 1'b1;
          cell_waddr = nb_idx_q[AddrW-1:0];
          stk_we     = 1'b1;
        end
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      dir_q       <= DIR_UP;
      load_pos_q  <= '0;
      scan_pos_q  <= '0;
      scan_col_q  <= '0;
      top_q       <= '0;
      count_q     <= '0;
      nb_idx_q    <= '0;
      nb_col_q    <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_in_grid) begin
              load_pos_q <= load_pos_q + PosW'(1);
            end
            if (s_axis_tlast) begin
              state_q <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (load_in_grid) begin
            load_pos_q <= load_pos_q + PosW'(1);
          end else begin
            scan_pos_q <= '0;
            scan_col_q <= '0;
            count_q    <= '0;
            state_q    <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK, ST_POP: begin
          if (state_q == ST_SCAN_CHK && cell_rdata) begin
            if (count_q != CountMax) begin
              count_q <= count_q + CountW'(1);
            end
            top_q   <= PosW'(1);
            state_q <= ST_POP;
          end else if (state_q == ST_POP && !top_empty) begin
            top_q   <= top_dec;
            dir_q   <= DIR_UP;
            state_q <= ST_NB_RD;
          end else if (scan_at_end) begin
            // raster scan done, region finished or cell was water
            state_q <= ST_DONE;
          end else begin
            scan_pos_q <= scan_pos_q + PosW'(1);
            scan_col_q <= ((scan_col_q + ColW'(1)) == cols) ? '0 : scan_col_q + ColW'(1);
            state_q    <= ST_SCAN_RD;
          end
        end
        ST_NB_RD: begin
          if (nb_ok) begin
            nb_idx_q <= nb_idx;
            nb_col_q <= nb_col;
            state_q  <= ST_NB_CHK;
          end else if (dir_q == DIR_RIGHT) begin
            state_q <= ST_POP;
          end else begin
            dir_q <= dir_e'(dir_q + 2'd1);
          end
        end
        ST_NB_CHK: begin
          if (cell_rdata) begin
            top_q <= top_q + PosW'(1);
          end
          if (dir_q == DIR_RIGHT) begin
            state_q <= ST_POP;
          end else begin
            dir_q   <= dir_e'(dir_q + 2'd1);
            state_q <= ST_NB_RD;
          end
        end
        ST_DONE: begin
          // wait for the previous count to leave the output register
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_count_q <= count_q;
            load_pos_q  <= '0;
            scan_pos_q  <= '0;
            scan_col_q  <= '0;
            top_q       <= '0;
            state_q     <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CountW){1'b0}}, out_count_q};

endmodule

@@ hw/rtl/gic_ram.sv @@
// simple dual-port memory: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module gic_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gic_dims.sv @@
// grid dimension registers with clamping and cell total
// depends on gic_pkg
`timescale 1ns / 1ps

module gic_dims
  import gic_pkg::*;
#(
  parameter int unsigned MaxRows = 64,
  parameter int unsigned MaxCols = 64,
  localparam int unsigned RowW  = $clog2(MaxRows + 1),
  localparam int unsigned ColW  = $clog2(MaxCols + 1),
  localparam int unsigned PosW  = $clog2(MaxRows * MaxCols + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic [ColW-1:0] cols_o,
  output logic [PosW-1:0] total_o
);

  logic [CfgW-1:0] rows_q, cols_q;
  logic [31:0] rows_ext, cols_ext;
  logic [RowW-1:0] rows_use;
  logic [RowW+ColW-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgDimReset;
      cols_q <= CfgDimReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxRows) begin
        rows_q <= cfg_data_i;
      end else begin
        cols_q <= cfg_data_i;
      end
    end
  end

  assign rows_ext = 32'(rows_q);
  assign cols_ext = 32'(cols_q);

  // zero means one, anything above the maximum means the maximum
  always_comb begin
    if (rows_ext == 32'd0) begin
      rows_use = RowW'(1);
    end else if (rows_ext > 32'(MaxRows)) begin
      rows_use = RowW'(MaxRows);
    end else begin
      rows_use = RowW'(rows_ext);
    end
    if (cols_ext == 32'd0) begin
      cols_o = ColW'(1);
    end else if (cols_ext > 32'(MaxCols)) begin
      cols_o = ColW'(MaxCols);
    end else begin
      cols_o = ColW'(cols_ext);
    end
  end

  assign prod    = {{ColW{1'b0}}, rows_use} * {{RowW{1'b0}}, cols_o};
  assign total_o = prod[PosW-1:0];

endmodule
